// File: hdl/phss_pkg.sv
// Package for the position-hold settle sequencer.
// Payload structs, register and step codes, FSM state type and handshake structs.
// No dependencies.
package phss_pkg;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        stick_active;
    logic [7:0]  update_tag;
    logic [15:0] ground_speed;
    logic        restart_hold;
    logic        keep_target;
  } in_item_t;

  typedef struct packed {
    logic [1:0] hold_status;
    logic       too_fast;
    logic       reset_nav;
    logic       capture_position;
    logic       run_controller;
    logic       track_error;
  } out_item_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_ACCEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GPS_LAG      = 2'd2;

  localparam logic [10:0] SETTLE_RST = 11'd100;
  localparam logic [9:0]  ACCEL_RST  = 10'd100;
  localparam logic [12:0] LAG_RST    = 13'd500;

  localparam logic [1:0] HS_NONE = 2'd0;
  localparam logic [1:0] HS_WORK = 2'd1;
  localparam logic [1:0] HS_DONE = 2'd2;

  localparam logic [2:0] STEP_OVERRIDE = 3'd0;
  localparam logic [2:0] STEP_START    = 3'd1;
  localparam logic [2:0] STEP_GATHER   = 3'd2;
  localparam logic [2:0] STEP_BRAKE    = 3'd3;
  localparam logic [2:0] STEP_LAG_ARM  = 3'd4;
  localparam logic [2:0] STEP_LAG_WAIT = 3'd5;
  localparam logic [2:0] STEP_HOLD     = 3'd6;

  // brake time divider: 16-bit dividend, 10-bit divisor
  localparam int DIV_BITS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);
  localparam int ACCEL_W  = 10;
  localparam int PROD_W   = DIV_BITS + ACCEL_W;
  localparam logic [ACCEL_W-1:0] MS_PER_S     = 10'd1000;
  localparam logic [PROD_W-1:0]  BRAKE_MIN_MS = 26'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_SCALE,
    ST_ARM,
    ST_EMIT
  } phss_state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_step;
    logic scale;
    logic arm;
    logic emit;
  } phss_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } phss_sts_t;

endpackage

// File: hdl/position_hold_settle_sequencer.sv
// Top level of the position-hold settle sequencer.
// Joins the controller FSM (phss_ctrl) and the datapath (phss_dp); depends on phss_pkg.
//
//  channel | ports                          | beat
//  in      | in_valid in_ready in_data      | one control tick
//  out     | out_valid out_ready out_data   | one result per tick
//  cfg     | cfg_valid cfg_ready cfg_index  | one register write
//          | cfg_data                       |
//
// A tick passes through capture, evaluate and emit; its result is registered at emit. A tick
// that arms the brake deadline also runs the 16-step serial divider for v/a, then the
// multiply and the clamp-and-add of the deadline, before emit.
// One tick is in flight at a time; in_ready returns once the result is registered.
// A stalled result holds in the output register; the next tick waits only at emit.
// Synchronous active-low reset; no clearing pass. cfg_ready is always high.
module position_hold_settle_sequencer #(
  parameter int unsigned STICK_CENTER_MS = 350,
  parameter int unsigned GATHER_MS       = 1000,
  parameter int unsigned MAX_BRAKE_MS    = 5000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  phss_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output phss_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [phss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [phss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import phss_pkg::*;

  phss_cmd_t cmd;
  phss_sts_t sts;

  assign cfg_ready = 1'b1;

  phss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  phss_dp #(
    .STICK_CENTER_MS (STICK_CENTER_MS),
    .GATHER_MS       (GATHER_MS),
    .MAX_BRAKE_MS    (MAX_BRAKE_MS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/phss_ctrl.sv
// Controller FSM of the position-hold settle sequencer.
// Sequences input capture, cascade evaluation, brake-time divide and result emit.
// Depends on phss_pkg.
module phss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  phss_pkg::phss_sts_t sts,
  output phss_pkg::phss_cmd_t cmd
);
  import phss_pkg::*;

  phss_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = sts.need_div ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_SCALE;
      end
      ST_SCALE: state_nxt = ST_ARM;
      ST_ARM:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_EVAL:  cmd.eval     = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_SCALE: cmd.scale    = 1'b1;
      ST_ARM:   cmd.arm      = 1'b1;
      ST_EMIT:  cmd.emit     = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/phss_dp.sv
// Datapath of the position-hold settle sequencer.
// Cascade state, config registers, serial brake-time divider and output register.
// Depends on phss_pkg.
module phss_dp #(
  parameter int unsigned STICK_CENTER_MS = 350,
  parameter int unsigned GATHER_MS       = 1000,
  parameter int unsigned MAX_BRAKE_MS    = 5000
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  phss_pkg::phss_cmd_t                  cmd,
  output phss_pkg::phss_sts_t                  sts,
  input  phss_pkg::in_item_t                   in_data,
  input  logic                                 cfg_we,
  input  logic [phss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [phss_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output phss_pkg::out_item_t                  out_data
);
  import phss_pkg::*;

  // config
  logic [10:0]        settle_r;
  logic [ACCEL_W-1:0] accel_r;
  logic [12:0]        lag_r;

  // cascade state
  logic [2:0]  step_r;
  logic [31:0] blind_r;
  logic [31:0] phase_r;
  logic [15:0] avg_r;
  logic [7:0]  tag_r;
  logic        limit_r;
  logic        ovr_r;
  logic        first_r;
  logic        reuse_r;

  in_item_t  item_r;
  out_item_t res_r;
  out_item_t out_r;
  logic      out_valid_r, out_valid_nxt;

  // divider
  logic [DIV_BITS-1:0]  quo_r;
  logic [ACCEL_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]    prod_r;

  // evaluation results
  logic [2:0]  step_nxt;
  logic [31:0] blind_nxt;
  logic [31:0] phase_nxt;
  logic [15:0] avg_nxt;
  logic [7:0]  tag_nxt;
  logic        limit_nxt, ovr_nxt, first_nxt, reuse_nxt;
  logic        need_div;
  out_item_t   res_nxt;

  function automatic logic [15:0] avg_in(input logic [15:0] a, input logic [15:0] s);
    logic [16:0] d;
    logic [15:0] r;
    if (s >= a) begin
      d = {1'b0, s} - {1'b0, a};
      r = a + d[16:1];
    end else begin
      d = {1'b0, a} - {1'b0, s} + 17'd1;
      r = a - d[16:1];
    end
    return r;
  endfunction

  always_comb begin
    logic        rn, cap, tr;
    logic [1:0]  st;
    logic [31:0] now;
    now       = item_r.now_ms;
    step_nxt  = step_r;
    blind_nxt = blind_r;
    phase_nxt = phase_r;
    avg_nxt   = avg_r;
    tag_nxt   = tag_r;
    limit_nxt = limit_r;
    ovr_nxt   = ovr_r;
    first_nxt = first_r;
    reuse_nxt = reuse_r;
    need_div  = 1'b0;
    rn        = 1'b0;
    cap       = 1'b0;
    tr        = 1'b0;
    st        = HS_NONE;

    if (item_r.restart_hold) begin
      first_nxt = 1'b1;
      reuse_nxt = item_r.keep_target;
    end
    if (first_nxt) begin
      step_nxt  = STEP_START;
      first_nxt = 1'b0;
      ovr_nxt   = 1'b0;
      blind_nxt = '0;
      rn        = 1'b1;
    end
    // stick release blind timer
    if (item_r.stick_active) begin
      blind_nxt = '0;
      step_nxt  = STEP_OVERRIDE;
      ovr_nxt   = 1'b1;
      first_nxt = 1'b0;
    end else if (ovr_nxt) begin
      if (blind_nxt == '0) blind_nxt = now + 32'(STICK_CENTER_MS);
      else if (now >= blind_nxt) first_nxt = 1'b1;
    end

    case (step_nxt)
      STEP_OVERRIDE: begin
        limit_nxt = 1'b1;
        reuse_nxt = 1'b0;
        rn        = 1'b1;
      end
      STEP_START, STEP_GATHER: begin
        st = HS_WORK;
        if (step_nxt == STEP_START) begin
          limit_nxt = 1'b1;
          phase_nxt = now + 32'(GATHER_MS);
          avg_nxt   = item_r.ground_speed;
          tag_nxt   = item_r.update_tag;
          step_nxt  = STEP_GATHER;
        end
        if (tag_nxt != item_r.update_tag) begin
          tag_nxt = item_r.update_tag;
          avg_nxt = avg_in(avg_nxt, item_r.ground_speed);
          if (now >= phase_nxt) begin
            phase_nxt = '0;
            step_nxt  = STEP_BRAKE;
          end
        end
      end
      STEP_BRAKE: begin
        st = HS_WORK;
        if (tag_nxt != item_r.update_tag) begin
          tag_nxt = item_r.update_tag;
          avg_nxt = avg_in(avg_nxt, item_r.ground_speed);
          if (avg_nxt < {5'd0, settle_r}) step_nxt = STEP_LAG_ARM;
          else if (phase_nxt == '0) need_div = 1'b1;
          else if (now >= phase_nxt) step_nxt = STEP_LAG_ARM;
        end
      end
      STEP_LAG_ARM, STEP_LAG_WAIT: begin
        st = HS_WORK;
        if (step_nxt == STEP_LAG_ARM) begin
          limit_nxt = 1'b0;
          phase_nxt = now + {19'd0, lag_r};
          step_nxt  = STEP_LAG_WAIT;
        end
        if (now >= phase_nxt) begin
          cap      = !reuse_nxt;
          rn       = 1'b1;
          step_nxt = STEP_HOLD;
        end
      end
      STEP_HOLD: begin
        limit_nxt = 1'b0;
        ovr_nxt   = 1'b0;
        tr        = 1'b1;
        st        = HS_DONE;
      end
      default: st = HS_NONE;
    endcase

    res_nxt.hold_status      = st;
    res_nxt.too_fast         = limit_nxt;
    res_nxt.reset_nav        = rn;
    res_nxt.capture_position = cap;
    res_nxt.run_controller   = !ovr_nxt;
    res_nxt.track_error      = tr;
  end

  // restoring divide step
  logic [ACCEL_W-1:0] accel_eff;
  logic [ACCEL_W:0]   trial;
  logic               q_bit;
  logic [ACCEL_W:0]   trial_sub;
  logic [PROD_W-1:0]  brake_t;

  assign accel_eff = (accel_r == '0) ? ACCEL_W'(1) : accel_r;
  assign trial     = {rem_r, quo_r[DIV_BITS-1]};
  assign q_bit     = trial >= {1'b0, accel_eff};
  assign trial_sub = trial - {1'b0, accel_eff};

  // clamp brake time to the allowed window
  always_comb begin
    if (prod_r < BRAKE_MIN_MS) brake_t = BRAKE_MIN_MS;
    else if (prod_r > PROD_W'(MAX_BRAKE_MS)) brake_t = PROD_W'(MAX_BRAKE_MS);
    else brake_t = prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r    <= SETTLE_RST;
      accel_r     <= ACCEL_RST;
      lag_r       <= LAG_RST;
      step_r      <= STEP_OVERRIDE;
      blind_r     <= '0;
      phase_r     <= '0;
      avg_r       <= '0;
      tag_r       <= '0;
      limit_r     <= 1'b0;
      ovr_r       <= 1'b0;
      first_r     <= 1'b0;
      reuse_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SETTLE_SPEED: settle_r <= cfg_data[10:0];
          REG_BRAKE_ACCEL:  accel_r  <= cfg_data[ACCEL_W-1:0];
          REG_GPS_LAG:      lag_r    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.eval) begin
        step_r  <= step_nxt;
        blind_r <= blind_nxt;
        phase_r <= phase_nxt;
        avg_r   <= avg_nxt;
        tag_r   <= tag_nxt;
        limit_r <= limit_nxt;
        ovr_r   <= ovr_nxt;
        first_r <= first_nxt;
        reuse_r <= reuse_nxt;
        cnt_r   <= DIV_CNT_W'(DIV_BITS - 1);
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.arm) phase_r <= item_r.now_ms + 32'(brake_t);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) item_r <= in_data;
    if (cmd.eval) begin
      res_r <= res_nxt;
      quo_r <= avg_nxt - {5'd0, settle_r};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DIV_BITS-2:0], q_bit};
      rem_r <= q_bit ? trial_sub[ACCEL_W-1:0] : trial[ACCEL_W-1:0];
    end
    if (cmd.scale) prod_r <= PROD_W'(quo_r) * PROD_W'(MS_PER_S);
    if (cmd.emit) out_r <= res_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign sts.need_div = need_div;
  assign sts.div_last = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// File: hdl/phss_chk.sv
// Port-level checker for the position-hold settle sequencer, with its bind.
// Watches the top level's ports only; depends on phss_pkg.
module phss_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input phss_pkg::out_item_t               out_data
);
  import phss_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one tick in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second tick taken while one is in flight");

  a_track_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.track_error |->
      out_data.hold_status == HS_DONE && !out_data.too_fast && out_data.run_controller)
    else $error("track_error outside the hold step");

  a_capture_nav: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.capture_position |->
      out_data.reset_nav && out_data.hold_status == HS_WORK)
    else $error("capture without navigation reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hold_status == HS_NONE || out_data.hold_status == HS_WORK ||
      out_data.hold_status == HS_DONE)
    else $error("bad hold status code");

endmodule

bind position_hold_settle_sequencer phss_chk u_phss_chk (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for position_hold_settle_sequencer: drives control ticks and
// register writes over valid/ready, predicts every result beat and compares it per field.
// Depends on phss_pkg and the RTL under hdl/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phss_pkg::*;

  localparam int unsigned STICK_MS     = 350;
  localparam int unsigned GATHER_MS    = 1000;
  localparam int unsigned MAX_BRAKE_MS = 5000;
  localparam int DRAIN_CYCLES = 25;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int PHASES      = 6;
  localparam int PHASE_TICKS = 190;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predicted sequencer state and settings
  logic [2:0]  step         = STEP_OVERRIDE;
  logic [31:0] blind_dl     = '0;
  logic [31:0] phase_dl     = '0;
  logic [15:0] avg_speed    = '0;
  logic [7:0]  last_tag     = '0;
  bit          tilt_limit   = 1'b0;
  bit          overridden   = 1'b0;
  bit          restart_pend = 1'b0;
  bit          reuse_wp     = 1'b0;
  logic [10:0] settle_cfg   = SETTLE_RST;
  logic [9:0]  accel_cfg    = ACCEL_RST;
  logic [12:0] lag_cfg      = LAG_RST;

  out_item_t   hold_results_q[$];
  plan_row_t   plan[$];
  int          err_count   = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;

  position_hold_settle_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_item_t outcome(logic [1:0] st, bit tf, bit rn, bit cp, bit rc, bit te);
    out_item_t r;
    r.hold_status      = st;
    r.too_fast         = tf;
    r.reset_nav        = rn;
    r.capture_position = cp;
    r.run_controller   = rc;
    r.track_error      = te;
    return r;
  endfunction

  // half-step average toward the new sample, rounding toward minus infinity
  function automatic void fold_speed(logic [15:0] spd);
    logic [16:0] gap;
    if (spd >= avg_speed) begin
      gap = {1'b0, spd - avg_speed};
      avg_speed = avg_speed + gap[16:1];
    end else begin
      gap = {1'b0, avg_speed} - {1'b0, spd} + 17'd1;
      avg_speed = avg_speed - gap[16:1];
    end
  endfunction

  function automatic out_item_t sequence_tick(in_item_t t);
    logic [1:0]  st;
    bit          nav, cap, trk;
    logic [31:0] accel, brake;
    st = HS_NONE;
    nav = 1'b0;
    cap = 1'b0;
    trk = 1'b0;
    if (t.restart_hold) begin
      restart_pend = 1'b1;
      reuse_wp = t.keep_target;
    end
    if (restart_pend) begin
      step = STEP_START;
      restart_pend = 1'b0;
      overridden = 1'b0;
      blind_dl = '0;
      nav = 1'b1;
    end
    if (t.stick_active) begin
      blind_dl = '0;
      step = STEP_OVERRIDE;
      overridden = 1'b1;
      restart_pend = 1'b0;
    end else if (overridden) begin
      // a deadline that wraps to zero stays unset and is armed on the next tick
      if (blind_dl == 0) blind_dl = t.now_ms + STICK_MS;
      else if (t.now_ms >= blind_dl) restart_pend = 1'b1;
    end
    case (step)
      STEP_OVERRIDE: begin
        tilt_limit = 1'b1;
        reuse_wp = 1'b0;
        nav = 1'b1;
      end
      STEP_START, STEP_GATHER: begin
        st = HS_WORK;
        if (step == STEP_START) begin
          tilt_limit = 1'b1;
          phase_dl = t.now_ms + GATHER_MS;
          avg_speed = t.ground_speed;
          last_tag = t.update_tag;
          step = STEP_GATHER;
        end
        if (last_tag != t.update_tag) begin
          last_tag = t.update_tag;
          fold_speed(t.ground_speed);
          if (t.now_ms >= phase_dl) begin
            phase_dl = '0;
            step = STEP_BRAKE;
          end
        end
      end
      STEP_BRAKE: begin
        st = HS_WORK;
        if (last_tag != t.update_tag) begin
          last_tag = t.update_tag;
          fold_speed(t.ground_speed);
          if (avg_speed < settle_cfg) begin
            step = STEP_LAG_ARM;
          end else if (phase_dl == 0) begin
            accel = (accel_cfg == 0) ? 32'd1 : 32'(accel_cfg);
            brake = ((32'(avg_speed) - 32'(settle_cfg)) / accel) * 32'd1000;
            if (brake < 1) brake = 32'd1;
            if (brake > MAX_BRAKE_MS) brake = MAX_BRAKE_MS;
            phase_dl = t.now_ms + brake;
          end else if (t.now_ms >= phase_dl) begin
            step = STEP_LAG_ARM;
          end
        end
      end
      STEP_LAG_ARM, STEP_LAG_WAIT: begin
        st = HS_WORK;
        if (step == STEP_LAG_ARM) begin
          tilt_limit = 1'b0;
          phase_dl = t.now_ms + lag_cfg;
          step = STEP_LAG_WAIT;
        end
        if (t.now_ms >= phase_dl) begin
          cap = !reuse_wp;
          nav = 1'b1;
          step = STEP_HOLD;
        end
      end
      STEP_HOLD: begin
        tilt_limit = 1'b0;
        overridden = 1'b0;
        trk = 1'b1;
        st = HS_DONE;
      end
      default: st = HS_NONE;
    endcase
    return outcome(st, tilt_limit, nav, cap, !overridden, trk);
  endfunction

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_result(out_item_t got, out_item_t want);
    if (got.hold_status !== want.hold_status)
      note_error($sformatf("hold_status got %0d want %0d", got.hold_status, want.hold_status));
    if (got.too_fast !== want.too_fast)
      note_error($sformatf("too_fast got %0b want %0b", got.too_fast, want.too_fast));
    if (got.reset_nav !== want.reset_nav)
      note_error($sformatf("reset_nav got %0b want %0b", got.reset_nav, want.reset_nav));
    if (got.capture_position !== want.capture_position)
      note_error($sformatf("capture_position got %0b want %0b",
                           got.capture_position, want.capture_position));
    if (got.run_controller !== want.run_controller)
      note_error($sformatf("run_controller got %0b want %0b",
                           got.run_controller, want.run_controller));
    if (got.track_error !== want.track_error)
      note_error($sformatf("track_error got %0b want %0b", got.track_error, want.track_error));
  endtask

  // result side: random stalls, compare each beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 28);
      if (out_valid && out_ready) begin
        if (hold_results_q.size() == 0) note_error("result beat with nothing expected");
        else check_result(out_data, hold_results_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_tick(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t pred;
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pred = sequence_tick(it);
    hold_results_q.push_back(typed ? want : pred);
  endtask

  // hold the sender until every outstanding result has been seen
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (hold_results_q.size() != 0);
  endtask

  task automatic write_settings(logic [10:0] settle, logic [9:0] accel, logic [12:0] lag);
    logic [CFG_IDX_W-1:0]  idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    idx[0] = REG_SETTLE_SPEED;
    idx[1] = REG_BRAKE_ACCEL;
    idx[2] = REG_GPS_LAG;
    val[0] = 13'(settle);
    val[1] = 13'(accel);
    val[2] = lag;
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        REG_SETTLE_SPEED: settle_cfg = val[k][10:0];
        REG_BRAKE_ACCEL:  accel_cfg  = val[k][9:0];
        REG_GPS_LAG:      lag_cfg    = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(logic [31:0] now, bit stick, logic [7:0] tag, logic [15:0] spd,
                         bit rs, bit kp, bit typed = 1'b0, out_item_t want = '0);
    plan_row_t row;
    row.stim.now_ms       = now;
    row.stim.stick_active = stick;
    row.stim.update_tag   = tag;
    row.stim.ground_speed = spd;
    row.stim.restart_hold = rs;
    row.stim.keep_target  = kp;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endtask

  initial begin
    in_item_t    it;
    logic [31:0] clock_ms;
    logic [7:0]  tag;
    int          vel, burst, r;

    // out of reset, no restart yet: manual override step
    add_row(32'd0, 0, 8'd0, 16'd0, 0, 0, 1, outcome(HS_NONE, 1, 1, 0, 1, 0));
    add_row(32'd10, 0, 8'd1, 16'hFFFF, 1, 0, 1, outcome(HS_WORK, 1, 1, 0, 1, 0));
    add_row(32'd20, 0, 8'd2, 16'd0, 0, 0);
    add_row(32'd1100, 0, 8'd3, 16'd0, 0, 0);
    // brake time clamps at its maximum
    add_row(32'd1110, 0, 8'd4, 16'd0, 0, 0);
    add_row(32'd1120, 0, 8'd4, 16'd0, 0, 0);
    add_row(32'd6110, 0, 8'd5, 16'hFFFF, 0, 0);
    add_row(32'd6120, 0, 8'd5, 16'd0, 0, 0);
    add_row(32'd6620, 0, 8'd5, 16'd0, 0, 0);
    add_row(32'd6630, 0, 8'd5, 16'd0, 0, 0, 1, outcome(HS_DONE, 0, 0, 0, 1, 1));
    add_row(32'd6640, 1, 8'd5, 16'd0, 0, 0, 1, outcome(HS_NONE, 1, 1, 0, 0, 0));
    // stick release where the blind deadline wraps to exactly zero
    add_row(32'hFFFF_FEA2, 0, 8'd5, 16'd0, 0, 0);
    add_row(32'hFFFF_FEA3, 0, 8'd5, 16'd0, 0, 0);
    add_row(32'd5, 0, 8'd5, 16'd0, 0, 0);
    // restart keeping the waypoint, settle below threshold without braking
    add_row(32'd10, 0, 8'h80, 16'd50, 1, 1);
    add_row(32'd1020, 0, 8'h81, 16'd50, 0, 0);
    add_row(32'd1030, 0, 8'h82, 16'd0, 0, 0);
    add_row(32'd1040, 0, 8'h82, 16'd0, 0, 0);
    add_row(32'd1540, 0, 8'h82, 16'd0, 0, 0, 1, outcome(HS_WORK, 0, 1, 0, 1, 0));
    add_row(32'd1550, 0, 8'hFF, 16'hFFFF, 0, 0);
    // brake time clamps at its minimum
    add_row(32'd2000, 0, 8'h10, 16'd150, 1, 0);
    add_row(32'd3100, 0, 8'h11, 16'd150, 0, 0);
    add_row(32'd3110, 0, 8'h12, 16'd150, 0, 0);
    add_row(32'd3111, 0, 8'h13, 16'd150, 0, 0);
    // stick wins over a restart in the same tick
    add_row(32'd3200, 1, 8'h13, 16'd150, 1, 1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) send_tick(plan[k].stim, plan[k].typed, plan[k].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_settings(11'd0, 10'd1, 13'd0);
        1: write_settings(11'd2000, 10'd1000, 13'd5000);
        2: write_settings(11'd150, 10'd0, 13'd250);
        4: write_settings(SETTLE_RST, ACCEL_RST, LAG_RST);
        default: write_settings(11'($urandom_range(0, 2000)), 10'($urandom_range(1, 1000)),
                                13'($urandom_range(0, 5000)));
      endcase
      if (p == 4) clock_ms = 32'hFFFF_C000;
      else if (p == 5) clock_ms = $urandom;
      else clock_ms = $urandom_range(0, 100000);
      tag = $urandom;
      vel = $urandom_range(0, 3000);
      burst = 0;

      for (int i = 0; i < PHASE_TICKS; i++) begin
        steady <= (p == 1 && i >= 40 && i < 160);
        if (p == 3 && i == 95) drain();
        r = $urandom_range(0, 99);
        if (r < 3) clock_ms = $urandom;
        else if (r < 15) clock_ms += $urandom_range(100, 900);
        else clock_ms += $urandom_range(1, 40);

        if (burst > 0) begin
          burst--;
          it.stick_active = 1'b1;
        end else if ($urandom_range(0, 99) < 4) begin
          burst = $urandom_range(0, 8);
          it.stick_active = 1'b1;
          vel = $urandom_range(0, 3000);
        end else begin
          it.stick_active = 1'b0;
        end

        // fresh GPS sample: decay the craft's speed toward rest
        if ($urandom_range(0, 99) < 60) begin
          tag += ($urandom_range(0, 19) == 0) ? 8'($urandom_range(2, 255)) : 8'd1;
          vel = vel * 3 / 4 + $urandom_range(0, 15);
        end

        it.now_ms       = clock_ms;
        it.update_tag   = tag;
        it.ground_speed = ($urandom_range(0, 99) < 5) ? 16'($urandom) : 16'(vel);
        it.restart_hold = (i == 0) || ($urandom_range(0, 99) < 2);
        it.keep_target  = $urandom_range(0, 1);
        send_tick(it);
      end
      drain();
    end

    steady <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/phss_pkg.sv
hdl/phss_ctrl.sv
hdl/phss_dp.sv
hdl/position_hold_settle_sequencer.sv
hdl/phss_chk.sv
tb/sv/tb.sv
